// ----- hdl/dbr_pkg.sv -----
// Shared types, codes and constants of the doorbell register block.
`default_nettype none

package dbr_pkg;

  // Default size of the peer table.
  localparam int PeerSlotsDef = 16;

  // Width of a per-peer vector count and of the vectors_per_peer register.
  localparam int CntW = 9;

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_MSI_ENABLE       = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_VECTORS_PER_PEER = 1'd1;
  localparam logic               MSI_ENABLE_RST       = 1'b1;
  localparam logic [CntW-1:0]    VECTORS_PER_PEER_RST = 9'd1;

  // Item commands.
  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_VECTOR = 3'd2,
    CMD_FDLESS = 3'd3,
    CMD_MAPPED = 3'd4,
    CMD_NOTIFY = 3'd5
  } cmd_e;

  // Bus access size that acts.
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Register offsets.
  localparam logic [7:0] ADDR_MASK     = 8'h00;
  localparam logic [7:0] ADDR_STATUS   = 8'h04;
  localparam logic [7:0] ADDR_POSITION = 8'h08;
  localparam logic [7:0] ADDR_DOORBELL = 8'h0C;
  localparam logic [7:0] ADDR_WR_MASK  = 8'hFC;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  access_size;
    logic [7:0]  address;
    logic [31:0] write_data;
    logic [15:0] peer_id;
    logic [7:0]  event_byte;
    logic [7:0]  event_vector;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        doorbell_fire;
    logic [15:0] doorbell_peer;
    logic [7:0]  doorbell_vector;
    logic        msi_fire;
    logic [7:0]  msi_vector;
    logic        dropped;
  } result_t;

  typedef struct packed {
    logic [31:0] intr_mask;
    logic [31:0] intr_status;
    logic [15:0] highest_peer;
    logic [15:0] own_id;
    logic        own_id_valid;
    logic        memory_mapped;
  } state_t;

  // Write request from the step logic to the peer table.
  typedef struct packed {
    logic            we;
    logic [CntW-1:0] data;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ----- hdl/shared_memory_doorbell_regs.sv -----
// An accepted item is held in the input register, its result in the output register.
// Throughput: one item per cycle while in_stall_o is low; the peer table read is
//   started at acceptance; its registered data meets the item in the input register.
// Reset: asynchronous, active low; control registers clear at once, then the peer
//   table is swept to zero entry by entry while in_stall_o stays high.
// Configuration writes are taken at any time, also during the sweep.
`default_nettype none

module shared_memory_doorbell_regs #(
  parameter int PEER_SLOTS = dbr_pkg::PeerSlotsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Item input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    command_i,
  input  wire logic [1:0]                    access_size_i,
  input  wire logic [7:0]                    address_i,
  input  wire logic [31:0]                   write_data_i,
  input  wire logic [15:0]                   peer_id_i,
  input  wire logic [7:0]                    event_byte_i,
  input  wire logic [7:0]                    event_vector_i,
  // Result output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [31:0]                        read_data_o,
  output logic                               irq_level_o,
  output logic                               doorbell_fire_o,
  output logic [15:0]                        doorbell_peer_o,
  output logic [7:0]                         doorbell_vector_o,
  output logic                               msi_fire_o,
  output logic [7:0]                         msi_vector_o,
  output logic                               dropped_o,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [dbr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dbr_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int IdxW = $clog2(PEER_SLOTS);

  // Configuration registers
  logic                     msi_en_q;
  logic [dbr_pkg::CntW-1:0] vpp_q;

  // Architectural register state
  dbr_pkg::state_t st_q, st_d;

  // Input register stage
  logic            s1_valid_q;
  dbr_pkg::item_t  s1_item_q;

  // Output register stage
  logic             out_valid_q;
  dbr_pkg::result_t res_q, res_d;

  // Peer table
  logic                     tbl_busy;
  logic [dbr_pkg::CntW-1:0] tbl_cnt;
  logic [IdxW-1:0]          tbl_rd_idx;
  dbr_pkg::tbl_wr_t         tbl_wr;

  logic in_accept;
  logic s1_adv;

  // The input register moves on when the output register is empty or being taken.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = tbl_busy || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Pick the table entry the item will need: doorbell destination for writes,
  // the named peer otherwise.
  assign tbl_rd_idx = (command_i == dbr_pkg::CMD_WRITE) ?
                      write_data_i[16 +: IdxW] : peer_id_i[IdxW-1:0];

  dbr_table #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_idx_i  (tbl_rd_idx),
    .rd_data_o (tbl_cnt),
    .wr_en_i   (tbl_wr.we && s1_adv),
    .wr_idx_i  (s1_item_q.peer_id[IdxW-1:0]),
    .wr_data_i (tbl_wr.data),
    .busy_o    (tbl_busy)
  );

  dbr_exec #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_exec (
    .st_i     (st_q),
    .item_i   (s1_item_q),
    .cnt_i    (tbl_cnt),
    .msi_en_i (msi_en_q),
    .vpp_i    (vpp_q),
    .st_o     (st_d),
    .res_o    (res_d),
    .tbl_o    (tbl_wr)
  );

  // Configuration registers: write when enabled, ignore unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msi_en_q <= dbr_pkg::MSI_ENABLE_RST;
      vpp_q    <= dbr_pkg::VECTORS_PER_PEER_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dbr_pkg::CFG_MSI_ENABLE:       msi_en_q <= cfg_data_i[0];
        dbr_pkg::CFG_VECTORS_PER_PEER: vpp_q    <= cfg_data_i[dbr_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // Control: stage valids and register state, which advances once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture the item on acceptance, the result when the stage advances.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.command      <= command_i;
      s1_item_q.access_size  <= access_size_i;
      s1_item_q.address      <= address_i;
      s1_item_q.write_data   <= write_data_i;
      s1_item_q.peer_id      <= peer_id_i;
      s1_item_q.event_byte   <= event_byte_i;
      s1_item_q.event_vector <= event_vector_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = res_q.read_data;
  assign irq_level_o       = res_q.irq_level;
  assign doorbell_fire_o   = res_q.doorbell_fire;
  assign doorbell_peer_o   = res_q.doorbell_peer;
  assign doorbell_vector_o = res_q.doorbell_vector;
  assign msi_fire_o        = res_q.msi_fire;
  assign msi_vector_o      = res_q.msi_vector;
  assign dropped_o         = res_q.dropped;

endmodule

`default_nettype wire

// ----- hdl/dbr_table.sv -----
// Peer vector-count table: one write port, one registered read port, clearing pass.
`default_nettype none

module dbr_table #(
  parameter int PEER_SLOTS = dbr_pkg::PeerSlotsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rd_en_i,
  input  wire logic [$clog2(PEER_SLOTS)-1:0]  rd_idx_i,
  output logic      [dbr_pkg::CntW-1:0]       rd_data_o,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(PEER_SLOTS)-1:0]  wr_idx_i,
  input  wire logic [dbr_pkg::CntW-1:0]       wr_data_i,
  output logic                                busy_o
);

  localparam int IdxW = $clog2(PEER_SLOTS);

  logic [dbr_pkg::CntW-1:0] mem [PEER_SLOTS];
  logic [dbr_pkg::CntW-1:0] rd_data_q;
  logic                     clr_busy_q;
  logic [IdxW-1:0]          clr_idx_q;

  // Sweep every entry to zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + IdxW'(1);
      if (clr_idx_q == IdxW'(PEER_SLOTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Write first: a read at the written entry sees the new count.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && !clr_busy_q && (wr_idx_i == rd_idx_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

`default_nettype wire

// ----- hdl/dbr_exec.sv -----
// Step logic: next register state, table write and result for one item.
`default_nettype none

module dbr_exec #(
  parameter int PEER_SLOTS = dbr_pkg::PeerSlotsDef
) (
  input  wire dbr_pkg::state_t              st_i,
  input  wire dbr_pkg::item_t               item_i,
  input  wire logic [dbr_pkg::CntW-1:0]     cnt_i,
  input  wire logic                         msi_en_i,
  input  wire logic [dbr_pkg::CntW-1:0]     vpp_i,
  output dbr_pkg::state_t                   st_o,
  output dbr_pkg::result_t                  res_o,
  output dbr_pkg::tbl_wr_t                  tbl_o
);

  localparam logic [16:0] Slots = 17'(PEER_SLOTS);

  always_comb begin
    logic        peer_in_range;
    logic [15:0] dest;
    logic [7:0]  vec;

    st_o  = st_i;
    res_o = '0;
    tbl_o = '0;
    peer_in_range = {1'b0, item_i.peer_id} < Slots;
    dest = item_i.write_data[31:16];
    vec  = item_i.write_data[7:0];

    case (item_i.command)
      dbr_pkg::CMD_READ: begin
        if (item_i.access_size == dbr_pkg::SIZE_WORD) begin
          case (item_i.address)
            dbr_pkg::ADDR_MASK: begin
              res_o.read_data = st_i.intr_mask;
            end
            dbr_pkg::ADDR_STATUS: begin
              res_o.read_data  = st_i.intr_status;
              st_o.intr_status = '0;
            end
            dbr_pkg::ADDR_POSITION: begin
              res_o.read_data = (st_i.memory_mapped && st_i.own_id_valid) ?
                                {16'h0000, st_i.own_id} : '1;
            end
            default: ;
          endcase
        end
      end
      dbr_pkg::CMD_WRITE: begin
        if (item_i.access_size == dbr_pkg::SIZE_WORD) begin
          case (item_i.address & dbr_pkg::ADDR_WR_MASK)
            dbr_pkg::ADDR_MASK:   st_o.intr_mask   = item_i.write_data;
            dbr_pkg::ADDR_STATUS: st_o.intr_status = item_i.write_data;
            dbr_pkg::ADDR_DOORBELL: begin
              if ((dest <= st_i.highest_peer) && ({1'b0, dest} < Slots) &&
                  ({1'b0, vec} < cnt_i)) begin
                res_o.doorbell_fire   = 1'b1;
                res_o.doorbell_peer   = dest;
                res_o.doorbell_vector = vec;
              end
            end
            default: ;
          endcase
        end
      end
      dbr_pkg::CMD_VECTOR: begin
        if (!peer_in_range) begin
          res_o.dropped = 1'b1;
        end else begin
          // Saturate at the configured vector count.
          if (cnt_i < vpp_i) begin
            tbl_o.we   = 1'b1;
            tbl_o.data = cnt_i + dbr_pkg::CntW'(1);
          end
          if (item_i.peer_id > st_i.highest_peer) begin
            st_o.highest_peer = item_i.peer_id;
          end
        end
      end
      dbr_pkg::CMD_FDLESS: begin
        if (!peer_in_range) begin
          res_o.dropped = 1'b1;
        end else if (cnt_i == '0) begin
          st_o.own_id       = item_i.peer_id;
          st_o.own_id_valid = 1'b1;
        end else begin
          tbl_o.we   = 1'b1;
          tbl_o.data = '0;
        end
      end
      dbr_pkg::CMD_MAPPED: begin
        st_o.memory_mapped = 1'b1;
        st_o.highest_peer  = '0;
      end
      dbr_pkg::CMD_NOTIFY: begin
        if (msi_en_i) begin
          if ({1'b0, item_i.event_vector} < vpp_i) begin
            res_o.msi_fire   = 1'b1;
            res_o.msi_vector = item_i.event_vector;
          end
        end else begin
          st_o.intr_status = {24'h000000, item_i.event_byte};
        end
      end
      default: ;
    endcase

    res_o.irq_level = |(st_o.intr_status & st_o.intr_mask);
  end

endmodule

`default_nettype wire
